>>> sv/mos_pkg.sv
package mos_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int SHIFT_W     = $clog2(MAX_SAMPLES / 2 + 1);

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
   localparam logic [1:0] ERR_TOO_MANY  = 2'd3;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic               last_item;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] median_value;
      logic [1:0]         error_code;
      logic [6:0]         sample_count;
   } rsp_word_type;

   typedef struct packed {
      logic insert;
      logic shift;
      logic clear;
   } cell_op_type;

endpackage

>>> sv/median_of_set.sv
// median_of_set: median of a set of signed 32-bit samples.
// req channel: one word per sample, last_item marks the end of the set.
// rsp channel: one word per set with median_value, error_code, sample_count.
// Samples are insertion-sorted into a row of 64 cells, one per clock, so a
// stream of non-final words is taken at one word per cycle.
// A word with last_item set is sorted in and then the row shifts toward its
// head until the middle samples reach the first two cells, one shift per
// cycle. The shift then ends, the sum is formed and the result is loaded
// once the output register is free; req_stall is high from the final word
// until the result is loaded.
// Samples beyond 64 are dropped and the result carries the too-many code.
// The result sits in an output register; while rsp_stall is high it holds,
// and the block waits with the next set unopened. Loading the result empties
// the row. Synchronous reset empties the row and drops any pending result.
module median_of_set
   import mos_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_CALC,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               exceeded_ff, exceeded_in;
   logic [SHIFT_W-1:0] shifts_ff, shifts_in;
   logic signed [32:0] sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   cell_op_type        op;
   logic signed [31:0] head_value, second_value;
   logic               accept, has_room, rsp_free;
   logic [COUNT_W-1:0] count_dec;
   logic signed [32:0] sum_adj;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign has_room  = (count_ff < COUNT_W'(MAX_SAMPLES));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign count_dec = count_in - COUNT_W'(1);
   assign sum_adj   = sum_ff + {32'd0, sum_ff[32]};

   mos_chain u_chain (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .sample       (req_word.sample_value),
      .head_value   (head_value),
      .second_value (second_value)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      exceeded_in  = exceeded_ff;
      shifts_in    = shifts_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      op           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  op.insert = 1'b1;
                  count_in  = count_ff + COUNT_W'(1);
               end else begin
                  exceeded_in = 1'b1;
               end
               if (req_word.last_item) begin
                  shifts_in = SHIFT_W'(count_dec >> 1);
                  state_in  = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (exceeded_ff || shifts_ff == '0) begin
               state_in = ST_CALC;
            end else begin
               op.shift  = 1'b1;
               shifts_in = shifts_ff - SHIFT_W'(1);
            end
         end
         ST_CALC: begin
            sum_in   = 33'(head_value) + 33'(second_value);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_word_in.sample_count = 7'(count_ff);
               rsp_word_in.median_value = '0;
               if (exceeded_ff) begin
                  rsp_word_in.error_code = ERR_TOO_MANY;
               end else if (count_ff[0]) begin
                  rsp_word_in.error_code   = ERR_NONE;
                  rsp_word_in.median_value = head_value;
               end else if (sum_ff[32:31] == 2'b01) begin
                  rsp_word_in.error_code = ERR_OVERFLOW;
               end else if (sum_ff[32:31] == 2'b10) begin
                  rsp_word_in.error_code = ERR_UNDERFLOW;
               end else begin
                  rsp_word_in.error_code   = ERR_NONE;
                  rsp_word_in.median_value = sum_adj[32:1];
               end
               rsp_valid_in = 1'b1;
               op.clear     = 1'b1;
               count_in     = '0;
               exceeded_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      shifts_ff   <= shifts_in;
      sum_ff      <= sum_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         exceeded_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         exceeded_ff  <= exceeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> sv/mos_cell.sv
module mos_cell
   import mos_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_op_type        op,
   input  logic signed [31:0] sample,
   input  logic signed [31:0] prev_value,
   input  logic               prev_valid,
   input  logic               prev_greater,
   input  logic signed [31:0] next_value,
   input  logic               next_valid,
   output logic signed [31:0] value,
   output logic               valid,
   output logic               greater
);

   logic signed [31:0] value_ff, value_in;
   logic               valid_ff, valid_in;

   // empty cells count as larger than any sample
   assign greater = !valid_ff || (value_ff > sample);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (op.clear) begin
         valid_in = 1'b0;
      end else if (op.shift) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (op.insert && greater) begin
         if (prev_greater) begin
            value_in = prev_value;
            valid_in = prev_valid;
         end else begin
            value_in = sample;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

>>> sv/mos_chain.sv
module mos_chain
   import mos_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_op_type        op,
   input  logic signed [31:0] sample,
   output logic signed [31:0] head_value,
   output logic signed [31:0] second_value
);

   logic signed [31:0] value [MAX_SAMPLES];
   logic               valid [MAX_SAMPLES];
   logic               greater [MAX_SAMPLES];

   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      logic signed [31:0] prev_value, next_value;
      logic               prev_valid, prev_greater, next_valid;

      if (i == 0) begin : g_first
         assign prev_value   = sample;
         assign prev_valid   = 1'b0;
         assign prev_greater = 1'b0;
      end else begin : g_mid
         assign prev_value   = value[i-1];
         assign prev_valid   = valid[i-1];
         assign prev_greater = greater[i-1];
      end

      if (i == MAX_SAMPLES - 1) begin : g_last
         assign next_value = sample;
         assign next_valid = 1'b0;
      end else begin : g_inner
         assign next_value = value[i+1];
         assign next_valid = valid[i+1];
      end

      mos_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .op           (op),
         .sample       (sample),
         .prev_value   (prev_value),
         .prev_valid   (prev_valid),
         .prev_greater (prev_greater),
         .next_value   (next_value),
         .next_valid   (next_valid),
         .value        (value[i]),
         .valid        (valid[i]),
         .greater      (greater[i])
      );
   end

   assign head_value   = value[0];
   assign second_value = value[1];

endmodule
